/* rtl/kmau_pkg.sv */
`timescale 1ns / 1ps
package kmau_pkg;

   localparam int COORD_W      = 16;
   localparam int SUM_W        = 32;
   localparam int CNT_W        = 17;
   localparam int DIST_W       = 33;
   localparam int SLOT_W       = 4;
   localparam int RESULT_LIMIT = 16;

   localparam logic [CNT_W-1:0]  COUNT_MAX = 17'd65536;
   localparam logic [DIST_W-1:0] DIST_MAX  = '1;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_CLASSIFY = 2'd1;
   localparam logic [1:0] CMD_UPDATE   = 2'd2;
   localparam logic [1:0] CMD_RSVD     = 2'd3;

   // search token moving down the cell chain
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [DIST_W-1:0]  best_d;
      logic [COORD_W-1:0] best_cx;
      logic [COORD_W-1:0] best_cy;
   } tok_type;

   // broadcast writes to the cells
   typedef struct packed {
      logic               load;
      logic               acc;
      logic               upd;
      logic               clr;
      logic [SLOT_W-1:0]  idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } ctl_type;

endpackage

/* rtl/kmau_cell.sv */
`timescale 1ns / 1ps
module kmau_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           active,
   input  kmau_pkg::ctl_type              ctl,
   input  kmau_pkg::tok_type              tok_in,
   input  logic [IDX_W-1:0]               idx_in,
   output kmau_pkg::tok_type              tok_out,
   output logic [IDX_W-1:0]               idx_out,
   output logic [kmau_pkg::COORD_W-1:0]   cx,
   output logic [kmau_pkg::COORD_W-1:0]   cy,
   output logic [kmau_pkg::SUM_W-1:0]     sx,
   output logic [kmau_pkg::SUM_W-1:0]     sy,
   output logic [kmau_pkg::CNT_W-1:0]     cnt
);

   logic [kmau_pkg::COORD_W-1:0] cx_ff, cy_ff;
   logic [kmau_pkg::SUM_W-1:0]   sx_ff, sy_ff;
   logic [kmau_pkg::CNT_W-1:0]   cnt_ff;
   kmau_pkg::tok_type            tok_ff, tok_in_n;
   logic [IDX_W-1:0]             idx_ff, idx_n;
   logic [kmau_pkg::COORD_W-1:0] dx, dy;
   logic [kmau_pkg::DIST_W-1:0]  d_sq;
   logic                         hit, take;

   assign hit = (32'(ctl.idx) == CELL_IDX);
   assign dx  = (tok_in.px >= cx_ff) ? tok_in.px - cx_ff : cx_ff - tok_in.px;
   assign dy  = (tok_in.py >= cy_ff) ? tok_in.py - cy_ff : cy_ff - tok_in.py;
   assign d_sq = {1'b0, 32'(dx) * 32'(dx)} + {1'b0, 32'(dy) * 32'(dy)};
   assign take = tok_in.valid && active && (d_sq < tok_in.best_d);

   always_comb begin
      tok_in_n = tok_in;
      idx_n    = idx_in;
      if (take) begin
         tok_in_n.best_d  = d_sq;
         tok_in_n.best_cx = cx_ff;
         tok_in_n.best_cy = cy_ff;
         idx_n            = IDX_W'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_n;
      if (reset) begin
         tok_ff <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
         if ((ctl.load || ctl.upd) && hit) begin
            cx_ff <= ctl.x;
            cy_ff <= ctl.y;
         end
         if (ctl.clr) begin
            sx_ff  <= '0;
            sy_ff  <= '0;
            cnt_ff <= '0;
         end else if (ctl.acc && hit) begin
            sx_ff  <= sx_ff + kmau_pkg::SUM_W'(ctl.x);
            sy_ff  <= sy_ff + kmau_pkg::SUM_W'(ctl.y);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;
   assign cx  = cx_ff;
   assign cy  = cy_ff;
   assign sx  = sx_ff;
   assign sy  = sy_ff;
   assign cnt = cnt_ff;

endmodule

/* rtl/kmau_div.sv */
`timescale 1ns / 1ps
module kmau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kmau_pkg::SUM_W-1:0]    dividend,
   input  logic [kmau_pkg::CNT_W-1:0]    divisor,
   output logic [kmau_pkg::COORD_W-1:0]  quotient,
   output logic                          done
);

   // quotient fits COORD_W bits since the sum is a sum of count coordinates
   logic [kmau_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [kmau_pkg::CNT_W-1:0]   dvs_ff;
   logic [kmau_pkg::COORD_W-1:0] sh_ff, sh_in;
   logic [kmau_pkg::COORD_W-1:0] q_ff, q_in;
   logic [4:0]                   step_ff, step_in;
   logic                         busy_ff, busy_in, done_ff, done_in;
   logic [kmau_pkg::CNT_W:0]     trial;

   assign trial = {rem_ff, sh_ff[kmau_pkg::COORD_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = kmau_pkg::CNT_W'(dividend[kmau_pkg::SUM_W-1:kmau_pkg::COORD_W]);
         sh_in   = dividend[kmau_pkg::COORD_W-1:0];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = {sh_ff[kmau_pkg::COORD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = kmau_pkg::CNT_W'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[kmau_pkg::COORD_W-2:0], 1'b1};
         end else begin
            rem_in = kmau_pkg::CNT_W'(trial);
            q_in   = {q_ff[kmau_pkg::COORD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == 5'(kmau_pkg::COORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (start) dvs_ff <= divisor;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

/* rtl/kmeans_assign_update.sv */
`timescale 1ns / 1ps
// k-means assign/update engine for 2-d points in unsigned q0.16. a load beat writes
// one centroid, a classify beat returns the nearest active centroid (ties to the lower
// index) and folds the point into that cluster's sums and saturating count, and an
// update beat returns one beat per active cluster with floor(sum/count) as the new
// centroid (empty clusters keep theirs and are flagged), then clears all sums. each
// cluster lives in one cell of a chain; a classify point walks the chain one cell per
// cycle. an update runs the 16-step shift-subtract divider (x and y in parallel) for
// each active cluster with members; empty clusters skip it. csr_data writes
// active_clusters (0 acts as 1, values above the cell count or RESULT_LIMIT are clamped
// to the smaller); the user may only change it while idle; the block does not check.
module kmeans_assign_update #(
   parameter int MAX_CLUSTERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data,      // active_clusters
   // request beats
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,     // cluster_slot[3:0], point_x[19:4], point_y[35:20]
   input  logic [1:0]   req_tuser,     // cmd[1:0]
   // result beats
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,     // cluster_index[3:0], distance_sq[36:4],
                                       // centroid_x[52:37], centroid_y[68:53],
                                       // member_count[85:69]
   output logic         rsp_tuser,     // empty_cluster
   output logic         rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_CLUSTERS);
   localparam int LIM   = (MAX_CLUSTERS < kmau_pkg::RESULT_LIMIT) ?
                          MAX_CLUSTERS : kmau_pkg::RESULT_LIMIT;
   localparam int CW    = kmau_pkg::COORD_W;

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_CEMIT = 3'd2;
   localparam logic [2:0] ST_UREAD = 3'd3;
   localparam logic [2:0] ST_UDIV  = 3'd4;
   localparam logic [2:0] ST_UEMIT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  act_ff;
   logic [4:0]  n_used;
   logic        accept, out_free;

   // cell chain
   kmau_pkg::tok_type            tok [MAX_CLUSTERS+1];
   logic [IDX_W-1:0]             tidx [MAX_CLUSTERS+1];
   logic [CW-1:0]                c_cx [MAX_CLUSTERS];
   logic [CW-1:0]                c_cy [MAX_CLUSTERS];
   logic [kmau_pkg::SUM_W-1:0]   c_sx [MAX_CLUSTERS];
   logic [kmau_pkg::SUM_W-1:0]   c_sy [MAX_CLUSTERS];
   logic [kmau_pkg::CNT_W-1:0]   c_cnt [MAX_CLUSTERS];
   kmau_pkg::ctl_type            ctl;

   // latched search result / update cluster
   logic [IDX_W-1:0]             k_ff, k_in;
   logic [kmau_pkg::DIST_W-1:0]  bd_ff;
   logic [CW-1:0]                bcx_ff, bcy_ff, px_ff, py_ff;
   logic [kmau_pkg::CNT_W-1:0]   ucnt_ff;
   logic                         div_start, dx_done, dy_done;
   logic [CW-1:0]                qx, qy;
   logic [kmau_pkg::CNT_W-1:0]   cnt_sel, cnt_new;
   logic                         sat, k_last;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [87:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) act_ff <= 5'd16;
      else if (csr_valid) act_ff <= csr_data;
   end

   // zero acts as one, clamp to the chain size or RESULT_LIMIT, whichever is smaller
   always_comb begin
      if (act_ff == 5'd0)         n_used = 5'd1;
      else if (act_ff > 5'(LIM))  n_used = 5'(LIM);
      else                        n_used = act_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // a classify beat enters the head of the chain
   always_comb begin
      tok[0].valid   = accept && (req_tuser == kmau_pkg::CMD_CLASSIFY);
      tok[0].px      = req_tdata[19:4];
      tok[0].py      = req_tdata[35:20];
      tok[0].best_d  = kmau_pkg::DIST_MAX;
      tok[0].best_cx = '0;
      tok[0].best_cy = '0;
      tidx[0]        = '0;
   end

   for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
      kmau_cell #(.IDX_W(IDX_W), .CELL_IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (32'(n_used) > g),
         .ctl     (ctl),
         .tok_in  (tok[g]),
         .idx_in  (tidx[g]),
         .tok_out (tok[g+1]),
         .idx_out (tidx[g+1]),
         .cx      (c_cx[g]),
         .cy      (c_cy[g]),
         .sx      (c_sx[g]),
         .sy      (c_sy[g]),
         .cnt     (c_cnt[g])
      );
   end

   assign div_start = (state_ff == ST_UREAD) && (c_cnt[k_ff] != '0);

   kmau_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(c_sx[k_ff]), .divisor(c_cnt[k_ff]), .quotient(qx), .done(dx_done)
   );
   kmau_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(c_sy[k_ff]), .divisor(c_cnt[k_ff]), .quotient(qy), .done(dy_done)
   );

   assign cnt_sel = c_cnt[k_ff];
   assign sat     = (cnt_sel == kmau_pkg::COUNT_MAX);
   assign cnt_new = sat ? cnt_sel : cnt_sel + 1'b1;
   assign k_last  = (32'(k_ff) + 1 == 32'(n_used));

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  kmau_pkg::CMD_LOAD: begin
                     ctl.load = 1'b1;
                     ctl.idx  = req_tdata[3:0];
                     ctl.x    = req_tdata[19:4];
                     ctl.y    = req_tdata[35:20];
                  end
                  kmau_pkg::CMD_CLASSIFY: state_in = ST_SCAN;
                  kmau_pkg::CMD_UPDATE: begin
                     k_in     = '0;
                     state_in = ST_UREAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (tok[MAX_CLUSTERS].valid) begin
               k_in     = tidx[MAX_CLUSTERS];
               state_in = ST_CEMIT;
            end
         end
         ST_CEMIT: begin
            if (out_free) begin
               ctl.acc      = !sat;
               ctl.idx      = kmau_pkg::SLOT_W'(k_ff);
               ctl.x        = px_ff;
               ctl.y        = py_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, cnt_new, bcy_ff, bcx_ff, bd_ff, 4'(k_ff)};
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UREAD: begin
            state_in = (c_cnt[k_ff] == '0) ? ST_UEMIT : ST_UDIV;
         end
         ST_UDIV: begin
            if (dx_done && dy_done) state_in = ST_UEMIT;
         end
         ST_UEMIT: begin
            if (out_free) begin
               ctl.upd      = (ucnt_ff != '0);
               ctl.idx      = kmau_pkg::SLOT_W'(k_ff);
               ctl.x        = qx;
               ctl.y        = qy;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, ucnt_ff,
                               (ucnt_ff != '0) ? qy : c_cy[k_ff],
                               (ucnt_ff != '0) ? qx : c_cx[k_ff],
                               {kmau_pkg::DIST_W{1'b0}}, 4'(k_ff)};
               rsp_user_in  = (ucnt_ff == '0);
               rsp_last_in  = k_last;
               if (k_last) begin
                  ctl.clr  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_UREAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_SCAN && tok[MAX_CLUSTERS].valid) begin
         bd_ff  <= tok[MAX_CLUSTERS].best_d;
         bcx_ff <= tok[MAX_CLUSTERS].best_cx;
         bcy_ff <= tok[MAX_CLUSTERS].best_cy;
         px_ff  <= tok[MAX_CLUSTERS].px;
         py_ff  <= tok[MAX_CLUSTERS].py;
      end
      if (state_ff == ST_UREAD) ucnt_ff <= c_cnt[k_ff];
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/kmau_checker.sv */
`timescale 1ns / 1ps
module kmau_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [87:0]  rsp_tdata,
   input logic         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[85:69] == 17'd0)
      else $error("empty cluster reported with members");

   a_empty_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[36:4] == 33'd0)
      else $error("update result carries a distance");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind kmeans_assign_update kmau_checker u_kmau_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
